>>> hdl/ole_pkg.sv
// ole_pkg: shared types and codes of the ordered list engine
// holds opcodes, status codes and the result record
// no dependencies
package ole_pkg;

    localparam int DATA_W = 32;
    localparam int POS_W  = 7;

    typedef enum logic [3:0] {
        OP_PUSH_BACK  = 4'd0,
        OP_PUSH_FRONT = 4'd1,
        OP_INSERT_AT  = 4'd2,
        OP_POP_BACK   = 4'd3,
        OP_POP_FRONT  = 4'd4,
        OP_REMOVE_AT  = 4'd5,
        OP_SEARCH     = 4'd6,
        OP_READ_AT    = 4'd7,
        OP_LENGTH     = 4'd8,
        OP_CLEAR      = 4'd9
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        logic [POS_W-1:0]         found;
        t_status                  status;
        logic [POS_W-1:0]         total;
    } t_result;

endpackage

>>> hdl/ole_mem.sv
// ole_mem: value store of the ordered list engine
// one write port, one read port, read data registered
// no package dependencies
module ole_mem #(
    parameter int DEPTH = 64
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  logic [31:0]                i_wdata,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [31:0]                o_rdata
);

    logic [31:0] r_store [DEPTH];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_store[i_waddr] <= i_wdata;
        end
        r_rdata <= r_store[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/ole_seq.sv
// ole_seq: operation sequencer of the ordered list engine
// decodes each request, walks the store to shift or scan, keeps the entry count
// depends on ole_pkg; drives the ports of ole_mem
module ole_seq #(
    parameter int CAPACITY = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_req_valid,
    output logic                        o_req_ready,
    input  logic [3:0]                  i_opcode,
    input  logic signed [31:0]          i_value,
    input  logic [6:0]                  i_position,
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output ole_pkg::t_result            o_res,
    output logic                        o_mem_we,
    output logic [$clog2(CAPACITY)-1:0] o_mem_waddr,
    output logic [31:0]                 o_mem_wdata,
    output logic [$clog2(CAPACITY)-1:0] o_mem_raddr,
    input  logic [31:0]                 i_mem_rdata
);

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = ((CW > 7) ? CW : 7) + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT_UP,
        S_PLACE,
        S_TAKE,
        S_SHIFT_DN,
        S_SCAN,
        S_READ,
        S_FINISH
    } t_state;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [AW-1:0]      r_j, n_j;
    logic [AW-1:0]      r_k, n_k;
    logic [31:0]        r_value, n_value;
    logic [31:0]        r_data, n_data;
    logic [CW-1:0]      r_found, n_found;
    ole_pkg::t_status   r_status, n_status;

    logic [CW-1:0]      cnt_m1;
    logic [CMPW-1:0]    pos_ext, cnt_ext, pos_m1;
    logic               full, empty, pos_zero;
    ole_pkg::t_opcode   op;

    assign cnt_m1   = r_count - CW'(1);
    assign pos_ext  = CMPW'(i_position);
    assign cnt_ext  = CMPW'(r_count);
    assign pos_m1   = pos_ext - CMPW'(1);
    assign full     = (r_count == CW'(CAPACITY));
    assign empty    = (r_count == '0);
    assign pos_zero = (i_position == '0);
    assign op       = ole_pkg::t_opcode'(i_opcode);

    always_comb begin
        logic [CMPW-1:0] ins_k;
        logic [CMPW-1:0] rm_k;
        logic            ins_bad;
        logic            rm_bad;

        n_state     = r_state;
        n_count     = r_count;
        n_j         = r_j;
        n_k         = r_k;
        n_value     = r_value;
        n_data      = r_data;
        n_found     = r_found;
        n_status    = r_status;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_j;
        o_mem_wdata = r_value;
        o_mem_raddr = r_j;

        ins_k   = (op == ole_pkg::OP_PUSH_FRONT) ? '0 : pos_m1;
        ins_bad = (op == ole_pkg::OP_INSERT_AT) &&
                  (pos_zero || (pos_ext > cnt_ext + CMPW'(1)));
        priority if (op == ole_pkg::OP_POP_BACK) begin
            rm_k = CMPW'(cnt_m1);
        end else if (op == ole_pkg::OP_POP_FRONT) begin
            rm_k = '0;
        end else begin
            rm_k = pos_m1;
        end
        rm_bad = empty || ((op == ole_pkg::OP_REMOVE_AT) && (pos_zero || (pos_ext > cnt_ext)));

        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_value  = i_value;
                    n_data   = '0;
                    n_found  = '0;
                    n_status = ole_pkg::ST_OK;
                    n_state  = S_FINISH;
                    unique case (op)
                        ole_pkg::OP_PUSH_BACK: begin
                            if (full) begin
                                n_status = ole_pkg::ST_FULL;
                            end else begin
                                o_mem_we    = 1'b1;
                                o_mem_waddr = r_count[AW-1:0];
                                o_mem_wdata = i_value;
                                n_count     = r_count + CW'(1);
                            end
                        end
                        ole_pkg::OP_PUSH_FRONT, ole_pkg::OP_INSERT_AT: begin
                            if (ins_bad) begin
                                n_status = ole_pkg::ST_MISS;
                            end else if (full) begin
                                n_status = ole_pkg::ST_FULL;
                            end else if (ins_k == cnt_ext) begin
                                // append, nothing to move
                                o_mem_we    = 1'b1;
                                o_mem_waddr = r_count[AW-1:0];
                                o_mem_wdata = i_value;
                                n_count     = r_count + CW'(1);
                            end else begin
                                o_mem_raddr = cnt_m1[AW-1:0];
                                n_j         = cnt_m1[AW-1:0];
                                n_k         = ins_k[AW-1:0];
                                n_state     = S_SHIFT_UP;
                            end
                        end
                        ole_pkg::OP_POP_BACK, ole_pkg::OP_POP_FRONT,
                        ole_pkg::OP_REMOVE_AT: begin
                            if (rm_bad) begin
                                n_status = ole_pkg::ST_MISS;
                            end else begin
                                o_mem_raddr = rm_k[AW-1:0];
                                n_k         = rm_k[AW-1:0];
                                n_state     = S_TAKE;
                            end
                        end
                        ole_pkg::OP_SEARCH: begin
                            if (empty) begin
                                n_status = ole_pkg::ST_MISS;
                            end else begin
                                o_mem_raddr = '0;
                                n_j         = '0;
                                n_state     = S_SCAN;
                            end
                        end
                        ole_pkg::OP_READ_AT: begin
                            if (pos_zero || (pos_ext > cnt_ext)) begin
                                n_status = ole_pkg::ST_MISS;
                            end else begin
                                o_mem_raddr = pos_m1[AW-1:0];
                                n_state     = S_READ;
                            end
                        end
                        ole_pkg::OP_LENGTH: begin
                            n_status = ole_pkg::ST_OK;
                        end
                        ole_pkg::OP_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                            n_status = ole_pkg::ST_MISS;
                        end
                    endcase
                end
            end
            S_SHIFT_UP: begin
                // entry read last cycle moves one slot towards the back
                o_mem_we    = 1'b1;
                o_mem_waddr = r_j + AW'(1);
                o_mem_wdata = i_mem_rdata;
                if (r_j == r_k) begin
                    n_state = S_PLACE;
                end else begin
                    n_j         = r_j - AW'(1);
                    o_mem_raddr = r_j - AW'(1);
                end
            end
            S_PLACE: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_k;
                o_mem_wdata = r_value;
                n_count     = r_count + CW'(1);
                n_state     = S_FINISH;
            end
            S_TAKE: begin
                n_data = i_mem_rdata;
                if (CW'(r_k) == cnt_m1) begin
                    n_count = cnt_m1;
                    n_state = S_FINISH;
                end else begin
                    n_j         = r_k + AW'(1);
                    o_mem_raddr = r_k + AW'(1);
                    n_state     = S_SHIFT_DN;
                end
            end
            S_SHIFT_DN: begin
                // entry read last cycle moves one slot towards the front
                o_mem_we    = 1'b1;
                o_mem_waddr = r_j - AW'(1);
                o_mem_wdata = i_mem_rdata;
                if (CW'(r_j) == cnt_m1) begin
                    n_count = cnt_m1;
                    n_state = S_FINISH;
                end else begin
                    n_j         = r_j + AW'(1);
                    o_mem_raddr = r_j + AW'(1);
                end
            end
            S_SCAN: begin
                if (i_mem_rdata == r_value) begin
                    n_found  = CW'(r_j) + CW'(1);
                    n_status = ole_pkg::ST_OK;
                    n_state  = S_FINISH;
                end else if (CW'(r_j) == cnt_m1) begin
                    n_status = ole_pkg::ST_MISS;
                    n_state  = S_FINISH;
                end else begin
                    n_j         = r_j + AW'(1);
                    o_mem_raddr = r_j + AW'(1);
                end
            end
            S_READ: begin
                n_data  = i_mem_rdata;
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_j      <= n_j;
        r_k      <= n_k;
        r_value  <= n_value;
        r_data   <= n_data;
        r_found  <= n_found;
        r_status <= n_status;
    end

    assign o_req_ready  = (r_state == S_IDLE);
    assign o_res_valid  = (r_state == S_FINISH);
    assign o_res.data   = (r_status == ole_pkg::ST_OK) ? r_data : '1;
    assign o_res.found  = (r_status == ole_pkg::ST_OK) ? 7'(r_found) : '0;
    assign o_res.status = r_status;
    assign o_res.total  = 7'(r_count);

endmodule

>>> hdl/ordered_list_engine_top.sv
// ordered_list_engine_top: bounded ordered list of signed 32-bit values
// store walks: none for push_back, append, length, clear and errors; pop/remove at k move
//   the entries behind k forward, insert at k moves them back, search scans from the front
// throughput: one request at a time; the store's read and write ports walk one entry per cycle
// reset: synchronous active low, clears the entry count and handshake state;
//   store contents are left as they are and need no clearing pass
module ordered_list_engine_top #(
    parameter int CAPACITY = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // item_value[31:0], position[38:32], zero pad
    input  logic [3:0]  s_axis_tuser,   // opcode[3:0]
    // result channel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // data_out[31:0], found_position[38:32],
                                        // entry_total[45:39], zero pad
    output logic [1:0]  m_axis_tuser    // status[1:0]
);

    localparam int AW = $clog2(CAPACITY);

    // sequencer to output register
    logic             seq_res_valid;
    logic             seq_res_ready;
    ole_pkg::t_result seq_res;

    // store port
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [31:0]      mem_wdata;
    logic [AW-1:0]    mem_raddr;
    logic [31:0]      mem_rdata;

    // output register, lets the sequencer move on while a result waits
    logic             r_m_valid;
    ole_pkg::t_result r_m_res;

    ole_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_opcode    (s_axis_tuser),
        .i_value     (s_axis_tdata[31:0]),
        .i_position  (s_axis_tdata[38:32]),
        .o_res_valid (seq_res_valid),
        .i_res_ready (seq_res_ready),
        .o_res       (seq_res),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    ole_mem #(
        .DEPTH (CAPACITY)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // slot free when empty or being drained this cycle
    assign seq_res_ready = !r_m_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (seq_res_ready) begin
            r_m_valid <= seq_res_valid;
        end
        if (seq_res_ready && seq_res_valid) begin
            r_m_res <= seq_res;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {2'b00, r_m_res.total, r_m_res.found, r_m_res.data};
    assign m_axis_tuser  = r_m_res.status;

endmodule

>>> hdl/ole_chk.sv
// ole_chk: port-level checks of the ordered list engine
// depends on ole_pkg; bound to ordered_list_engine_top below
module ole_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // no result straight out of reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // failed requests report minus one and no position
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != ole_pkg::ST_OK)
            |-> (m_axis_tdata[31:0] == 32'hFFFF_FFFF) && (m_axis_tdata[38:32] == 7'd0))
        else $error("error result carries data");

    // one request in work at a time
    a_one: assert property (@(posedge i_clk)
        i_rst_n && s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while busy");

endmodule

bind ordered_list_engine_top ole_chk u_ole_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

>>> dv/tb_ordered_list_engine_top.sv
`timescale 1ns / 1ps
// tb_ordered_list_engine_top: self-checking bench for the ordered list engine
// drives list operations on the request stream and checks every result against a shadow list
// depends on ole_pkg and ordered_list_engine_top
module tb_ordered_list_engine_top;

    localparam int DATA_W       = ole_pkg::DATA_W;
    localparam int POS_W        = ole_pkg::POS_W;
    localparam int CAPACITY     = 64;
    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 5;
    localparam int HOLD_CYCLES  = 300;
    // worst case walk is a full shift plus pipeline
    localparam int TAIL_CYCLES  = CAPACITY + 8;
    localparam int CYCLE_LIMIT  = 1_000_000;

    // codes the block does not know, they must come back as a miss
    localparam logic [3:0] UNUSED_OP_LO = 4'd10;
    localparam logic [3:0] UNUSED_OP_HI = 4'd15;

    typedef enum int {
        MODE_GROW,
        MODE_SHRINK,
        MODE_MIXED
    } t_traffic_mode;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;   // item_value[31:0], position[38:32], zero pad
    logic [3:0]  s_axis_tuser  = '0;   // opcode[3:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;         // data_out[31:0], found_position[38:32],
                                       // entry_total[45:39], zero pad
    logic [1:0]  m_axis_tuser;         // status[1:0]

    // shadow copy of the list contents
    logic signed [DATA_W-1:0] list_mem [CAPACITY];
    int                       list_len = 0;

    ole_pkg::t_result pending_results [$];
    ole_pkg::t_result got_result;
    ole_pkg::t_result want_result;

    int error_count  = 0;
    int result_index = 0;
    int cycle_count  = 0;
    int burst_left   = 0;

    // receiver stall pattern and long hold-off
    int hold_asked       = 0;
    int hold_seen        = 0;
    int hold_left        = 0;
    int stall_style      = 0;
    int stall_phase_left = 0;

    ordered_list_engine_top #(
        .CAPACITY(CAPACITY)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #(HALF_PERIOD) i_clk = 1'b1;
        #(HALF_PERIOD) i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // shadow list
    // ---------------------------------------------------------------

    // open a gap at zero-based slot and store the value there
    function automatic void list_place(int slot, logic signed [DATA_W-1:0] value);
        int k;
        for (k = list_len; k > slot; k--)
            list_mem[k] = list_mem[k-1];
        list_mem[slot] = value;
        list_len++;
    endfunction

    // close the gap at zero-based slot, returning what was there
    function automatic logic signed [DATA_W-1:0] list_take(int slot);
        logic signed [DATA_W-1:0] value;
        int k;
        value = list_mem[slot];
        for (k = slot; k < list_len - 1; k++)
            list_mem[k] = list_mem[k+1];
        list_len--;
        return value;
    endfunction

    // apply one request to the shadow list and build the result it should give
    function automatic ole_pkg::t_result list_apply(logic [3:0] op,
                                                    logic signed [DATA_W-1:0] value,
                                                    logic [POS_W-1:0] pos);
        ole_pkg::t_result r;
        bit               hit;
        int               k;
        r.data   = '0;
        r.found  = '0;
        r.status = ole_pkg::ST_OK;
        hit      = 1'b0;
        case (op)
            ole_pkg::OP_PUSH_BACK, ole_pkg::OP_PUSH_FRONT: begin
                if (list_len >= CAPACITY)
                    r.status = ole_pkg::ST_FULL;
                else
                    list_place((op == ole_pkg::OP_PUSH_BACK) ? list_len : 0, value);
            end
            ole_pkg::OP_INSERT_AT: begin
                // index check wins over the full check
                if (pos < 1 || pos > list_len + 1)
                    r.status = ole_pkg::ST_MISS;
                else if (list_len >= CAPACITY)
                    r.status = ole_pkg::ST_FULL;
                else
                    list_place(pos - 1, value);
            end
            ole_pkg::OP_POP_BACK, ole_pkg::OP_POP_FRONT: begin
                if (list_len == 0)
                    r.status = ole_pkg::ST_MISS;
                else
                    r.data = list_take((op == ole_pkg::OP_POP_BACK) ? list_len - 1 : 0);
            end
            ole_pkg::OP_REMOVE_AT: begin
                if (pos < 1 || pos > list_len)
                    r.status = ole_pkg::ST_MISS;
                else
                    r.data = list_take(pos - 1);
            end
            ole_pkg::OP_SEARCH: begin
                for (k = 0; k < list_len; k++) begin
                    if (!hit && list_mem[k] == value) begin
                        hit     = 1'b1;
                        r.found = POS_W'(k + 1);
                    end
                end
                if (!hit)
                    r.status = ole_pkg::ST_MISS;
            end
            ole_pkg::OP_READ_AT: begin
                if (pos < 1 || pos > list_len)
                    r.status = ole_pkg::ST_MISS;
                else
                    r.data = list_mem[pos - 1];
            end
            ole_pkg::OP_LENGTH: begin
            end
            ole_pkg::OP_CLEAR: begin
                list_len = 0;
            end
            default: begin
                r.status = ole_pkg::ST_MISS;
            end
        endcase
        if (r.status != ole_pkg::ST_OK) begin
            r.data  = -1;
            r.found = '0;
        end
        r.total = POS_W'(list_len);
        return r;
    endfunction

    // ---------------------------------------------------------------
    // request side
    // ---------------------------------------------------------------

    // offer one request, idling between bursts, and log what it should return
    task automatic send_request(input logic [3:0] op, input logic signed [DATA_W-1:0] value,
                                input logic [POS_W-1:0] pos);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 30);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, pos, value};
        s_axis_tuser  <= op;
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        pending_results.push_back(list_apply(op, value, pos));
    endtask

    // small values give duplicates and minus one, the rest spreads over the full range
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $signed($urandom_range(0, 7)) - 3;
            4: begin
                case ($urandom_range(0, 3))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7fff_ffff;
                    2: return -1;
                    default: return 0;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // mostly a usable index, now and then anything the field allows
    function automatic logic [POS_W-1:0] pick_position(int top);
        if ($urandom_range(0, 4) == 0 || top < 1)
            return POS_W'($urandom_range(0, 127));
        return POS_W'($urandom_range(1, top));
    endfunction

    task automatic wait_for_results();
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // result side
    // ---------------------------------------------------------------

    // stall pattern: stretches of always ready, coin-flip and mostly stalled,
    // with a long hold-off whenever the test asks for one
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_seen != hold_asked) begin
            hold_seen     <= hold_asked;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            if (stall_phase_left == 0) begin
                stall_style      <= $urandom_range(0, 2);
                stall_phase_left <= $urandom_range(20, 200);
            end else begin
                stall_phase_left <= stall_phase_left - 1;
            end
            case (stall_style)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= 1'($urandom_range(0, 1));
                default: m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic compare_field(input string name, input logic [DATA_W-1:0] want,
                                 input logic [DATA_W-1:0] got);
        if (got !== want) begin
            $display("%0t: result %0d %s mismatch, expected %h, actual %h",
                     $time, result_index, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_result.data   = m_axis_tdata[31:0];
            got_result.found  = m_axis_tdata[38:32];
            got_result.total  = m_axis_tdata[45:39];
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual data %h status %0d",
                         $time, got_result.data, m_axis_tuser);
                error_count++;
            end else begin
                want_result = pending_results.pop_front();
                compare_field("data_out", want_result.data, got_result.data);
                compare_field("found_position", DATA_W'(want_result.found),
                              DATA_W'(got_result.found));
                compare_field("status", DATA_W'(want_result.status), DATA_W'(m_axis_tuser));
                compare_field("entry_total", DATA_W'(want_result.total),
                              DATA_W'(got_result.total));
            end
            result_index++;
        end
    end

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // every operation that needs an entry, on an empty list, plus bad insert indexes
    task automatic test_empty_list();
        send_request(ole_pkg::OP_POP_BACK, 0, 0);
        send_request(ole_pkg::OP_POP_FRONT, 0, 0);
        send_request(ole_pkg::OP_REMOVE_AT, 0, 1);
        send_request(ole_pkg::OP_READ_AT, 0, 1);
        send_request(ole_pkg::OP_SEARCH, 0, 0);
        send_request(ole_pkg::OP_INSERT_AT, 5, 0);
        send_request(ole_pkg::OP_INSERT_AT, 5, 2);
    endtask

    // edits at both ends and in the middle, lookups, duplicates and unknown codes
    task automatic test_edits_and_lookups();
        send_request(ole_pkg::OP_PUSH_BACK, 32'sh7fff_ffff, 0);
        send_request(ole_pkg::OP_PUSH_FRONT, 32'sh8000_0000, 127);
        send_request(ole_pkg::OP_INSERT_AT, -1, 2);
        send_request(ole_pkg::OP_INSERT_AT, 0, 4);     // append through insert at length+1
        send_request(ole_pkg::OP_PUSH_BACK, -1, 0);    // duplicate of a middle entry
        send_request(ole_pkg::OP_SEARCH, -1, 0);       // first match wins
        send_request(ole_pkg::OP_READ_AT, 0, 2);       // stored minus one reads back as ok
        send_request(ole_pkg::OP_READ_AT, 0, 127);
        send_request(ole_pkg::OP_REMOVE_AT, 0, 0);
        send_request(ole_pkg::OP_REMOVE_AT, 0, 5);
        send_request(ole_pkg::OP_LENGTH, 32'sh5555_aaaa, 64);
        send_request(UNUSED_OP_LO, 7, 1);
        send_request(UNUSED_OP_HI, -1, 127);
        send_request(ole_pkg::OP_POP_FRONT, 0, 0);
        send_request(ole_pkg::OP_POP_BACK, 0, 0);
        send_request(ole_pkg::OP_SEARCH, 12345, 0);
        send_request(ole_pkg::OP_CLEAR, 0, 0);
        send_request(ole_pkg::OP_LENGTH, 0, 0);
    endtask

    // fill to capacity, bounce off the full list, edit both ends, then drain past empty
    task automatic test_full_list();
        int k;
        send_request(ole_pkg::OP_CLEAR, 0, 0);
        for (k = 0; k < CAPACITY; k++)
            send_request(ole_pkg::OP_PUSH_BACK, pick_value(), 0);
        send_request(ole_pkg::OP_PUSH_BACK, 1, 0);
        send_request(ole_pkg::OP_PUSH_FRONT, 1, 0);
        send_request(ole_pkg::OP_INSERT_AT, 1, POS_W'(CAPACITY + 1));   // well placed but full
        send_request(ole_pkg::OP_INSERT_AT, 1, POS_W'(CAPACITY + 2));   // bad index first
        send_request(ole_pkg::OP_INSERT_AT, 1, 0);
        send_request(ole_pkg::OP_SEARCH, list_mem[CAPACITY-1], 0);
        send_request(ole_pkg::OP_READ_AT, 0, POS_W'(CAPACITY));
        send_request(ole_pkg::OP_REMOVE_AT, 0, POS_W'(CAPACITY));
        send_request(ole_pkg::OP_READ_AT, 0, POS_W'(CAPACITY));
        send_request(ole_pkg::OP_INSERT_AT, pick_value(), POS_W'(CAPACITY));
        send_request(ole_pkg::OP_REMOVE_AT, 0, 1);
        send_request(ole_pkg::OP_INSERT_AT, pick_value(), 1);
        for (k = 0; k <= CAPACITY; k++)
            send_request((k % 2 == 0) ? ole_pkg::OP_POP_FRONT : ole_pkg::OP_POP_BACK, 0, 0);
    endtask

    // results back up while requests keep coming, so the input must stall
    task automatic test_input_backpressure();
        int k;
        hold_asked <= hold_asked + 1;
        for (k = 0; k < 16; k++)
            send_request((k % 3 == 0) ? ole_pkg::OP_PUSH_FRONT : ole_pkg::OP_PUSH_BACK,
                         pick_value(), 0);
    endtask

    // long runs of edits and lookups in phases that grow, shrink or churn the list
    task automatic test_random_traffic(input int count);
        t_traffic_mode           mode;
        int                      n;
        int                      pick;
        int                      grow_pct;
        int                      shrink_pct;
        logic [3:0]              op;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]        pos;
        mode       = MODE_MIXED;
        grow_pct   = 33;
        shrink_pct = 33;
        for (n = 0; n < count; n++) begin
            if (n % 40 == 0) begin
                mode = t_traffic_mode'($urandom_range(0, 2));
                case (mode)
                    MODE_GROW: begin
                        grow_pct   = 60;
                        shrink_pct = 18;
                    end
                    MODE_SHRINK: begin
                        grow_pct   = 18;
                        shrink_pct = 60;
                    end
                    default: begin
                        grow_pct   = 33;
                        shrink_pct = 33;
                    end
                endcase
            end
            pick  = $urandom_range(0, 99);
            value = pick_value();
            pos   = '0;
            if (pick == 99) begin
                // rare noise: wipe the list or send a code the block does not know
                if ($urandom_range(0, 1) == 0)
                    op = ole_pkg::OP_CLEAR;
                else
                    op = 4'($urandom_range(UNUSED_OP_LO, UNUSED_OP_HI));
                pos = POS_W'($urandom_range(0, 127));
            end else if (pick < grow_pct) begin
                case ($urandom_range(0, 2))
                    0: op = ole_pkg::OP_PUSH_BACK;
                    1: op = ole_pkg::OP_PUSH_FRONT;
                    default: begin
                        op  = ole_pkg::OP_INSERT_AT;
                        pos = pick_position(list_len + 1);
                    end
                endcase
            end else if (pick < grow_pct + shrink_pct) begin
                case ($urandom_range(0, 2))
                    0: op = ole_pkg::OP_POP_BACK;
                    1: op = ole_pkg::OP_POP_FRONT;
                    default: begin
                        op  = ole_pkg::OP_REMOVE_AT;
                        pos = pick_position(list_len);
                    end
                endcase
            end else begin
                case ($urandom_range(0, 4))
                    0, 1: begin
                        op = ole_pkg::OP_SEARCH;
                        // mostly look for something that is there
                        if (list_len > 0 && $urandom_range(0, 9) < 7)
                            value = list_mem[$urandom_range(0, list_len - 1)];
                    end
                    2, 3: begin
                        op  = ole_pkg::OP_READ_AT;
                        pos = pick_position(list_len);
                    end
                    default: op = ole_pkg::OP_LENGTH;
                endcase
            end
            send_request(op, value, pos);
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_list();
        test_edits_and_lookups();
        test_full_list();
        test_input_backpressure();
        test_random_traffic(900);

        s_axis_tvalid <= 1'b0;
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> files.f
hdl/ole_pkg.sv
hdl/ole_mem.sv
hdl/ole_seq.sv
hdl/ordered_list_engine_top.sv
hdl/ole_chk.sv
dv/tb_ordered_list_engine_top.sv
